@@ rtl/cost_matrix_reduction_bound_unit_macros.svh @@
// Assertion macros used by the checker file of the cost matrix reduction unit.
`ifndef COST_MATRIX_REDUCTION_BOUND_UNIT_MACROS_SVH
`define COST_MATRIX_REDUCTION_BOUND_UNIT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define CMRB_ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("cmrb assertion failed");

// Next-cycle implication, disabled during reset.
`define CMRB_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("cmrb assertion failed");

`endif

@@ rtl/cmrb_pkg.sv @@
// Shared types and constants of the cost matrix reduction unit.
`default_nettype none
package cmrb_pkg;

  localparam int CITY_BITS      = 4;
  localparam int PORT_COST_BITS = 16;
  localparam int BOUND_BITS     = 20;
  localparam logic [BOUND_BITS-1:0] BOUND_MAX = 20'hFFFFF;

  typedef struct packed {
    logic done;
    logic wr_en;
  } eng_stat_t;

endpackage
`default_nettype wire

@@ rtl/cmrb_ram.sv @@
// Generic simple dual-port RAM with one write port and a registered read port.
`default_nettype none
module cmrb_ram #(
  parameter int WIDTH = 17,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule
`default_nettype wire

@@ rtl/cmrb_engine.sv @@
// Row and column reduction sequencer that walks the stored matrix through the RAM.
`default_nettype none
module cmrb_engine #(
  parameter int MAX_CITIES = 8,
  parameter int COST_BITS  = 16
) (
  input  wire logic                                    clk,
  input  wire logic                                    rst,
  input  wire logic                                    start,
  input  wire logic [$clog2(MAX_CITIES+1)-1:0]         side,
  output logic      [$clog2(MAX_CITIES*MAX_CITIES)-1:0] addr,
  input  wire logic [COST_BITS:0]                      rd_data,
  output logic      [COST_BITS:0]                      wr_data,
  output cmrb_pkg::eng_stat_t                          stat,
  output logic      [cmrb_pkg::BOUND_BITS-1:0]         bound
);
  import cmrb_pkg::*;

  localparam int AW = $clog2(MAX_CITIES*MAX_CITIES);
  localparam int IW = $clog2(MAX_CITIES);
  localparam int NW = $clog2(MAX_CITIES+1);
  localparam int DW = COST_BITS + 1;
  localparam int SW = ((COST_BITS > BOUND_BITS) ? COST_BITS : BOUND_BITS) + 1;
  localparam logic [DW-1:0] INF = {1'b1, {COST_BITS{1'b0}}};

  typedef enum logic [2:0] {
    S_IDLE, S_SCAN_RD, S_SCAN_ACC, S_SUB_RD, S_SUB_WR
  } state_t;

  state_t          state;
  logic [IW-1:0]   line;
  logic [IW-1:0]   pos;
  logic            col_pass;
  logic [DW-1:0]   acc;
  logic            done;

  logic [IW-1:0]   last_idx;
  logic            pos_last;
  logic            line_last;
  logic [IW-1:0]   row;
  logic [IW-1:0]   col;
  logic [DW-1:0]   mn;
  logic [SW-1:0]   sum_wide;
  logic [BOUND_BITS-1:0] bound_next;

  function automatic logic [DW-1:0] take_min(input logic [DW-1:0] a, input logic [DW-1:0] c);
    logic [DW-1:0] r;
    r = a;
    if (!c[COST_BITS]) begin
      if (a[COST_BITS] || (c[COST_BITS-1:0] < a[COST_BITS-1:0])) begin
        r = c;
      end
    end
    return r;
  endfunction

  always_comb begin
    last_idx   = IW'(side - NW'(1));
    pos_last   = (pos == last_idx);
    line_last  = (line == last_idx);
    row        = col_pass ? pos : line;
    col        = col_pass ? line : pos;
    addr       = AW'(AW'(row) * AW'(side) + AW'(col));
    mn         = take_min(acc, rd_data);
    sum_wide   = SW'(bound) + SW'(mn[COST_BITS-1:0]);
    bound_next = (sum_wide > SW'(BOUND_MAX)) ? BOUND_MAX : sum_wide[BOUND_BITS-1:0];
    wr_data    = {1'b0, rd_data[COST_BITS-1:0] - acc[COST_BITS-1:0]};
    stat.wr_en = (state == S_SUB_WR) && !rd_data[COST_BITS];
    stat.done  = done;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
      bound <= '0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            line     <= '0;
            pos      <= '0;
            col_pass <= 1'b0;
            acc      <= INF;
            bound    <= '0;
            state    <= S_SCAN_RD;
          end
        end
        S_SCAN_RD: begin
          state <= S_SCAN_ACC;
        end
        S_SCAN_ACC: begin
          if (pos_last) begin
            pos <= '0;
            if (mn[COST_BITS]) begin
              acc      <= INF;
              line     <= line_last ? '0 : line + IW'(1);
              col_pass <= col_pass | line_last;
              if (col_pass && line_last) begin
                done  <= 1'b1;
                state <= S_IDLE;
              end else begin
                state <= S_SCAN_RD;
              end
            end else begin
              acc   <= mn;
              bound <= bound_next;
              state <= S_SUB_RD;
            end
          end else begin
            acc   <= mn;
            pos   <= pos + IW'(1);
            state <= S_SCAN_RD;
          end
        end
        S_SUB_RD: begin
          state <= S_SUB_WR;
        end
        S_SUB_WR: begin
          if (pos_last) begin
            pos      <= '0;
            acc      <= INF;
            line     <= line_last ? '0 : line + IW'(1);
            col_pass <= col_pass | line_last;
            if (col_pass && line_last) begin
              done  <= 1'b1;
              state <= S_IDLE;
            end else begin
              state <= S_SCAN_RD;
            end
          end else begin
            pos   <= pos + IW'(1);
            state <= S_SUB_RD;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

@@ rtl/cost_matrix_reduction_bound_unit.sv @@
// Top level of the reduced cost matrix lower bound unit.
//
//   Channel  Direction  Handshake                  Payload
//   in       input      in_valid / in_stall        entry_cost, entry_infinite
//   out      output     out_valid / out_stall      reduced_cost, reduced_infinite,
//                                                  lower_bound, last_entry
//   cfg      input      cfg_wr_en                  cfg_wr_data (city_count)
//
// Loading takes one beat per cycle while in_stall is low into the matrix RAM, n*n beats for side n.
// The reduction sequencer then visits each RAM entry through a read state and an accumulate
// or write state on each scan and each subtract sweep, sharing the single RAM read port.
// Each result then passes the read, capture and output states, waiting while out_stall is held.
// Reset is synchronous; it sets the side to 8 and restarts loading at entry 0.
// No input beat is taken while a matrix is being reduced or streamed out.
`default_nettype none
module cost_matrix_reduction_bound_unit #(
  parameter int MAX_CITIES = 8,
  parameter int COST_BITS  = 16
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                cfg_wr_en,
  input  wire logic [cmrb_pkg::CITY_BITS-1:0]      cfg_wr_data,
  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire logic [cmrb_pkg::PORT_COST_BITS-1:0] entry_cost,
  input  wire logic                                entry_infinite,
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output logic      [cmrb_pkg::PORT_COST_BITS-1:0] reduced_cost,
  output logic                                     reduced_infinite,
  output logic      [cmrb_pkg::BOUND_BITS-1:0]     lower_bound,
  output logic                                     last_entry
);
  import cmrb_pkg::*;

  localparam int AW = $clog2(MAX_CITIES*MAX_CITIES);
  localparam int NW = $clog2(MAX_CITIES+1);
  localparam int DW = COST_BITS + 1;
  localparam int XW = (COST_BITS > PORT_COST_BITS) ? COST_BITS : PORT_COST_BITS;

  typedef enum logic [2:0] {
    S_LOAD, S_REDUCE, S_EMIT_RD, S_EMIT_CAP, S_EMIT_OUT
  } state_t;

  state_t                state;
  logic [CITY_BITS-1:0]  city_count;
  logic [AW-1:0]         load_pos;
  logic [AW-1:0]         emit_pos;

  logic [NW-1:0]         side;
  logic [AW-1:0]         last_addr;
  logic                  in_accept;
  logic                  eng_start;
  logic [AW-1:0]         eng_addr;
  logic [DW-1:0]         eng_wr_data;
  eng_stat_t             eng_stat;
  logic [BOUND_BITS-1:0] eng_bound;

  logic                  ram_we;
  logic [AW-1:0]         ram_wa;
  logic [DW-1:0]         ram_wd;
  logic [AW-1:0]         ram_ra;
  logic [DW-1:0]         ram_rd;
  logic [XW-1:0]         in_ext;
  logic [XW-1:0]         out_ext;
  logic                  emit_last;

  always_comb begin
    if (city_count < CITY_BITS'(2)) begin
      side = NW'(2);
    end else if (city_count > CITY_BITS'(MAX_CITIES)) begin
      side = NW'(MAX_CITIES);
    end else begin
      side = NW'(city_count);
    end
    last_addr = AW'(AW'(side) * AW'(side) - AW'(1));
    in_stall  = (state != S_LOAD);
    in_accept = in_valid && !in_stall;
    eng_start = in_accept && !cfg_wr_en && (load_pos == last_addr);
    emit_last = (emit_pos == last_addr);
    in_ext    = XW'(entry_cost);
    out_ext   = XW'(ram_rd[COST_BITS-1:0]);
    if (state == S_LOAD) begin
      ram_we = in_accept;
      ram_wa = load_pos;
      ram_wd = entry_infinite ? {1'b1, {COST_BITS{1'b0}}} : {1'b0, in_ext[COST_BITS-1:0]};
    end else begin
      ram_we = eng_stat.wr_en;
      ram_wa = eng_addr;
      ram_wd = eng_wr_data;
    end
    ram_ra = (state == S_REDUCE) ? eng_addr : emit_pos;
  end

  cmrb_ram #(
    .WIDTH (DW),
    .DEPTH (MAX_CITIES*MAX_CITIES)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_wa),
    .wr_data (ram_wd),
    .rd_addr (ram_ra),
    .rd_data (ram_rd)
  );

  cmrb_engine #(
    .MAX_CITIES (MAX_CITIES),
    .COST_BITS  (COST_BITS)
  ) u_engine (
    .clk     (clk),
    .rst     (rst),
    .start   (eng_start),
    .side    (side),
    .addr    (eng_addr),
    .rd_data (ram_rd),
    .wr_data (eng_wr_data),
    .stat    (eng_stat),
    .bound   (eng_bound)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_LOAD;
      city_count <= CITY_BITS'(8);
      load_pos   <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        city_count <= cfg_wr_data;
      end
      case (state)
        S_LOAD: begin
          if (cfg_wr_en) begin
            load_pos <= '0;
          end else if (in_accept) begin
            if (load_pos == last_addr) begin
              load_pos <= '0;
              state    <= S_REDUCE;
            end else begin
              load_pos <= load_pos + AW'(1);
            end
          end
        end
        S_REDUCE: begin
          if (eng_stat.done) begin
            emit_pos <= '0;
            state    <= S_EMIT_RD;
          end
        end
        S_EMIT_RD: begin
          state <= S_EMIT_CAP;
        end
        S_EMIT_CAP: begin
          out_valid        <= 1'b1;
          reduced_infinite <= ram_rd[COST_BITS];
          reduced_cost     <= ram_rd[COST_BITS] ? '0 : out_ext[PORT_COST_BITS-1:0];
          lower_bound      <= emit_last ? eng_bound : '0;
          last_entry       <= emit_last;
          state            <= S_EMIT_OUT;
        end
        S_EMIT_OUT: begin
          if (!out_stall) begin
            out_valid <= 1'b0;
            if (last_entry) begin
              state <= S_LOAD;
            end else begin
              emit_pos <= emit_pos + AW'(1);
              state    <= S_EMIT_RD;
            end
          end
        end
        default: begin
          state <= S_LOAD;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

@@ rtl/cmrb_checker.sv @@
// Port-level checker of the cost matrix reduction unit and its bind.
`default_nettype none
`include "cost_matrix_reduction_bound_unit_macros.svh"
module cmrb_checker (
  input wire logic                                clk,
  input wire logic                                rst,
  input wire logic                                in_valid,
  input wire logic                                in_stall,
  input wire logic                                out_valid,
  input wire logic                                out_stall,
  input wire logic [cmrb_pkg::PORT_COST_BITS-1:0] reduced_cost,
  input wire logic                                reduced_infinite,
  input wire logic [cmrb_pkg::BOUND_BITS-1:0]     lower_bound,
  input wire logic                                last_entry
);
  import cmrb_pkg::*;

  // A waiting result beat stays offered until it is taken.
  `CMRB_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid)

  // No input beat is taken while results are being streamed out.
  `CMRB_ASSERT_IMPLY(a_no_load_during_emit, clk, rst, out_valid, in_stall)

  // A result beat is never offered in a cycle that takes an input beat.
  `CMRB_ASSERT_IMPLY(a_no_emit_on_load, clk, rst, in_valid && !in_stall, !out_valid)

  // The bound is shown only on the final beat of a matrix.
  `CMRB_ASSERT_IMPLY(a_bound_on_last, clk, rst, out_valid && !last_entry, lower_bound == '0)

  // An infinite entry carries a zero cost.
  `CMRB_ASSERT_IMPLY(a_inf_zero, clk, rst, out_valid && reduced_infinite, reduced_cost == '0)

endmodule

bind cost_matrix_reduction_bound_unit cmrb_checker u_cmrb_checker (
  .clk              (clk),
  .rst              (rst),
  .in_valid         (in_valid),
  .in_stall         (in_stall),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .reduced_cost     (reduced_cost),
  .reduced_infinite (reduced_infinite),
  .lower_bound      (lower_bound),
  .last_entry       (last_entry)
);
`default_nettype wire
